FILE: design/prb_pkg.sv
// shared types and constants for the packet ring buffer with chunked drain
// no dependencies; imported by prb_ctrl, the top level and the checker
`default_nettype none

package prb_pkg;

    localparam int DATA_W  = 8;
    localparam int QUEUE_W = 12;
    localparam int DROP_W  = 32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CHUNK  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              opcode;
        logic [DATA_W-1:0] data_byte;
        logic              first_of_block;
        logic [DATA_W-1:0] block_length;
        logic              last_of_block;
        logic              link_ready;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [DATA_W-1:0]  out_byte;
        logic               chunk_end;
        logic               block_accepted;
        logic [QUEUE_W-1:0] queued_bytes;
        logic [DROP_W-1:0]  drop_count;
    } t_out_item;

    // control side of a result, registered in the controller
    typedef struct packed {
        logic valid;
        logic kind;
        logic chunk_end;
        logic accepted;
    } t_out_meta;

endpackage

`default_nettype wire

FILE: design/prb_byte_ram.sv
// byte store: one write port, one read port with registered read data
// no package dependency
`default_nettype none

module prb_byte_ram #(
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/prb_ctrl.sv
// pointer, admission and drain control for the packet ring buffer
// depends on prb_pkg; drives the write and read ports of prb_byte_ram
`default_nettype none

module prb_ctrl #(
    parameter int BUF_DEPTH = 4096,
    parameter int CHUNK_MAX = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire prb_pkg::t_in_item            i_item,
    output logic                              o_busy,
    output logic                              o_we,
    output logic [$clog2(BUF_DEPTH)-1:0]      o_waddr,
    output logic                              o_re,
    output logic [$clog2(BUF_DEPTH)-1:0]      o_raddr,
    output prb_pkg::t_out_meta                o_meta,
    output logic [prb_pkg::QUEUE_W-1:0]       o_queued,
    output logic [prb_pkg::DROP_W-1:0]        o_drops
);

    import prb_pkg::*;

    localparam int IW = $clog2(BUF_DEPTH);
    localparam int SW = ((IW > DATA_W) ? IW : DATA_W) + 1;
    localparam int CW = $clog2(CHUNK_MAX + 1);
    localparam int LW = ((IW + 1) > CW) ? (IW + 1) : CW;

    localparam logic [SW-1:0]   DEPTH_S  = SW'(BUF_DEPTH);
    localparam logic [IW:0]     DEPTH_T  = (IW + 1)'(BUF_DEPTH);
    localparam logic [LW-1:0]   CHUNK_L  = LW'(CHUNK_MAX);
    localparam logic [IW-1:0]   LAST_IDX = IW'(BUF_DEPTH - 1);
    localparam logic [CW-1:0]   ONE_C    = CW'(1);

    t_state              r_state, n_state;
    logic [IW-1:0]       r_head, r_tail, r_used;
    logic [DROP_W-1:0]   r_drops;
    logic                r_adm;
    logic [DATA_W-1:0]   r_off, r_decl;
    logic [IW-1:0]       r_rd_ptr;
    logic [CW-1:0]       r_rem;
    t_out_meta           r_meta, n_meta;

    logic                w_app, w_flush, w_over, w_adm, w_wr, w_commit, w_rd;
    logic [DATA_W-1:0]   w_decl, w_off, w_off_after;
    logic [SW-1:0]       w_over_sum, w_pos_sum, w_pos, w_head_sum, w_head_new;
    logic [LW-1:0]       w_len_full, w_len;
    logic [IW:0]         w_len_t, w_tail_sum;
    logic [IW-1:0]       w_tail_new;
    logic [IW+QUEUE_W-1:0] w_used_ext;

    assign w_app   = i_accept && (i_item.opcode == OP_APPEND);
    assign w_flush = i_accept && (i_item.opcode == OP_FLUSH) && i_item.link_ready
                     && (r_used != '0);

    // admission: free = depth - used - 1 < length  <=>  used + length >= depth
    assign w_over_sum = SW'(r_used) + SW'(i_item.block_length);
    assign w_over     = (w_over_sum >= DEPTH_S);

    always_comb begin
        if (i_item.first_of_block) begin
            w_adm  = !w_over;
            w_decl = w_over ? r_decl : i_item.block_length;
            w_off  = '0;
        end else begin
            w_adm  = r_adm;
            w_decl = r_decl;
            w_off  = r_off;
        end
    end

    assign w_wr        = w_app && w_adm && (w_off < w_decl);
    assign w_off_after = w_off + DATA_W'(w_wr);
    assign w_commit    = w_app && i_item.last_of_block && w_adm;

    // an admitted block never exceeds depth - 1, so one subtract wraps it
    assign w_pos_sum  = SW'(r_head) + SW'(w_off);
    assign w_pos      = (w_pos_sum >= DEPTH_S) ? (w_pos_sum - DEPTH_S) : w_pos_sum;
    assign w_head_sum = SW'(r_head) + SW'(w_off_after);
    assign w_head_new = (w_head_sum >= DEPTH_S) ? (w_head_sum - DEPTH_S) : w_head_sum;

    // chunk length: contiguous run from the tail, capped
    always_comb begin
        if (r_head > r_tail) begin
            w_len_full = LW'((IW + 1)'(r_head) - (IW + 1)'(r_tail));
        end else begin
            w_len_full = LW'(DEPTH_T - (IW + 1)'(r_tail));
        end
        w_len = (w_len_full > CHUNK_L) ? CHUNK_L : w_len_full;
    end

    assign w_len_t    = w_len[IW:0];
    assign w_tail_sum = (IW + 1)'(r_tail) + w_len_t;
    assign w_tail_new = (w_tail_sum >= DEPTH_T) ? IW'(w_tail_sum - DEPTH_T)
                                                : w_tail_sum[IW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_flush) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_rem == ONE_C) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            ST_DRAIN: begin
                o_busy = 1'b1;
                w_rd   = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
                w_rd   = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_meta.valid     = w_app || w_rd;
        n_meta.kind      = w_rd ? KIND_CHUNK : KIND_STATUS;
        n_meta.chunk_end = w_rd && (r_rem == ONE_C);
        n_meta.accepted  = w_app && w_adm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_used   <= '0;
            r_drops  <= '0;
            r_adm    <= 1'b0;
            r_off    <= '0;
            r_decl   <= '0;
            r_rd_ptr <= '0;
            r_rem    <= '0;
            r_meta   <= '0;
        end else begin
            r_state <= n_state;
            r_meta  <= n_meta;
            if (w_app) begin
                r_decl <= w_decl;
                if (i_item.first_of_block && w_over) begin
                    r_drops <= r_drops + 1'b1;
                end
                if (w_commit) begin
                    r_head <= w_head_new[IW-1:0];
                    r_used <= r_used + IW'(w_off_after);
                    r_adm  <= 1'b0;
                    r_off  <= '0;
                end else begin
                    r_adm <= w_adm;
                    r_off <= w_off_after;
                end
            end
            if (w_flush) begin
                r_rd_ptr <= r_tail;
                r_rem    <= CW'(w_len);
                r_tail   <= w_tail_new;
                r_used   <= r_used - IW'(w_len_t);
            end else if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : (r_rd_ptr + 1'b1);
                r_rem    <= r_rem - ONE_C;
            end
        end
    end

    assign w_used_ext = {{QUEUE_W{1'b0}}, r_used};

    assign o_we     = w_wr;
    assign o_waddr  = w_pos[IW-1:0];
    assign o_re     = w_rd;
    assign o_raddr  = r_rd_ptr;
    assign o_meta   = r_meta;
    assign o_queued = w_used_ext[QUEUE_W-1:0];
    assign o_drops  = r_drops;

endmodule

`default_nettype wire

FILE: design/packet_ring_buffer_chunked_drain_unit.sv
// Packet ring buffer with all-or-nothing block admission and chunked drain.
//
// An item is accepted at a rising edge with start high and busy low.
// Append items (opcode 0) never raise busy and may follow back to back;
// each gives one status result on the cycle after it is accepted.
// A flush item (opcode 1) with link_ready set and bytes queued starts a
// drain of N = min(contiguous committed bytes from the tail, CHUNK_MAX)
// bytes: busy is high while the drain sequencer reads the
// byte store one address a cycle, and each byte appears in the cycle
// after its read, as the store registers its read data. The next item
// may be accepted in the cycle that shows the final byte. A flush that
// finds the link not ready or no bytes queued gives no result.
// Results are strobed on o_strobe for one cycle and cannot be held off.
// Synchronous reset clears pointers, counters and the drain sequencer; the
// byte store itself is not cleared and only committed bytes are read.
`default_nettype none

module packet_ring_buffer_chunked_drain_unit #(
    parameter int BUF_DEPTH = 4096,
    parameter int CHUNK_MAX = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire prb_pkg::t_in_item  i_item,
    output logic                    o_strobe,
    output prb_pkg::t_out_item      o_result
);

    import prb_pkg::*;

    localparam int IW = $clog2(BUF_DEPTH);

    logic                 w_accept;
    logic                 w_we, w_re;
    logic [IW-1:0]        w_waddr, w_raddr;
    logic [DATA_W-1:0]    w_rdata;
    t_out_meta            w_meta;
    logic [QUEUE_W-1:0]   w_queued;
    logic [DROP_W-1:0]    w_drops;

    assign w_accept = start && !busy;

    prb_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .CHUNK_MAX (CHUNK_MAX)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_busy   (busy),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .o_meta   (w_meta),
        .o_queued (w_queued),
        .o_drops  (w_drops)
    );

    prb_byte_ram #(
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.data_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // status results carry a zero byte; counts are the state after the step
    always_comb begin
        o_result.result_kind    = w_meta.kind;
        o_result.out_byte       = (w_meta.kind == KIND_CHUNK) ? w_rdata : '0;
        o_result.chunk_end      = w_meta.chunk_end;
        o_result.block_accepted = w_meta.accepted;
        o_result.queued_bytes   = w_queued;
        o_result.drop_count     = w_drops;
    end

    assign o_strobe = w_meta.valid;

endmodule

`default_nettype wire

FILE: design/prb_checker.sv
// port-level checks for packet_ring_buffer_chunked_drain_unit
// depends on prb_pkg; attached to the top level by the bind below
`default_nettype none

module prb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire prb_pkg::t_in_item  i_item,
    input wire logic               o_strobe,
    input wire prb_pkg::t_out_item o_result
);

    import prb_pkg::*;

    // every accepted append gives a status item on the next cycle
    a_append_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_APPEND))
        |=> (o_strobe && (o_result.result_kind == KIND_STATUS)))
        else $error("append without status item");

    // a chunk byte that is not the last is shown while the drain still runs
    a_chunk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.result_kind == KIND_CHUNK) && !o_result.chunk_end)
        |-> busy)
        else $error("chunk cut short");

    // end of a drain is marked by the final chunk byte
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n))
        |-> (o_strobe && (o_result.result_kind == KIND_CHUNK) && o_result.chunk_end))
        else $error("drain ended without final chunk byte");

    // drop count rises by at most one between results strobed in consecutive cycles
    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && $past(i_rst_n))
        |-> (DROP_W'(o_result.drop_count - $past(o_result.drop_count)) <= DROP_W'(1)))
        else $error("drop count jumped");

endmodule

bind packet_ring_buffer_chunked_drain_unit prb_checker u_prb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
